FILE: rtl/growing_vq_bearing_estimator_macros.svh
// Assertion macros for the growing VQ bearing estimator
`ifndef GROWING_VQ_BEARING_ESTIMATOR_MACROS_SVH
`define GROWING_VQ_BEARING_ESTIMATOR_MACROS_SVH
// Clocked implication, disabled in reset
`define GVQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset
`define GVQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/gvq_pkg.sv
// Shared types and constants for the growing VQ bearing estimator
package gvq_pkg;
  localparam int RING_SIZE_DEF   = 8;
  localparam int PROTO_MAX_DEF   = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_PROTO_RATE = 3'd1;
  localparam logic [2:0] REG_BEAR_RATE  = 3'd2;
  localparam logic [2:0] REG_LESION_AFT = 3'd3;
  localparam logic [2:0] REG_FORCE_LES  = 3'd4;
  localparam logic [2:0] REG_PROTO_LIM  = 3'd5;

  localparam logic [15:0] PROX_CAP = 16'd32768;

  // Step a value toward a target: cur + floor(rate*(tgt-cur)/65536)
  function automatic logic signed [25:0] rate_step(input logic signed [25:0] cur,
                                                   input logic signed [25:0] tgt,
                                                   input logic [15:0] rate);
    logic signed [42:0] prod;
    begin
      prod = $signed({1'b0, rate}) * (tgt - cur);
      rate_step = cur + 26'(prod >>> 16);
    end
  endfunction
endpackage

FILE: rtl/gvq_ram.sv
// Generic single-port-write RAM with registered read
module gvq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/gvq_lane.sv
// One lane: squared difference of one ring element against one stored sample
module gvq_lane #(
  parameter int SAMPLE_BITS = gvq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic [SAMPLE_BITS-1:0]   ring,
  input  logic [SAMPLE_BITS-1:0]   proto,
  output logic [2*SAMPLE_BITS-1:0] sq
);
  import gvq_pkg::*;
  logic [SAMPLE_BITS-1:0] diff;
  assign diff = (proto > ring) ? proto - ring : ring - proto;
  always_ff @(posedge clk) begin
    sq <= diff * diff;
  end
endmodule

FILE: rtl/gvq_merge.sv
// Merge stage: sum lane squares and track the nearest prototype
module gvq_merge #(
  parameter int RING_SIZE   = gvq_pkg::RING_SIZE_DEF,
  parameter int SAMPLE_BITS = gvq_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_BITS    = 5
) (
  input  logic                                  clk,
  input  logic                                  clear,
  input  logic                                  sq_valid,
  input  logic [IDX_BITS-1:0]                   sq_idx,
  input  logic [RING_SIZE-1:0][2*SAMPLE_BITS-1:0] sq,
  output logic                                  have_best,
  output logic [2*SAMPLE_BITS+2:0]              best,
  output logic [IDX_BITS-1:0]                   best_idx
);
  import gvq_pkg::*;
  localparam int DW = 2*SAMPLE_BITS+3;
  logic [DW-1:0] row_dist;
  always_comb begin
    row_dist = '0;
    for (int i = 0; i < RING_SIZE; i++) row_dist = row_dist + DW'(sq[i]);
  end
  always_ff @(posedge clk) begin
    if (clear) begin
      have_best <= 1'b0;
    end else if (sq_valid && (!have_best || row_dist < best)) begin
      have_best <= 1'b1;
      best      <= row_dist;
      best_idx  <= sq_idx;
    end
  end
endmodule

FILE: rtl/growing_vq_bearing_estimator.sv
// Top level of the growing VQ bearing estimator
// A start with ring_valid latches the ring; the scan reads one prototype per cycle
// across RING_SIZE lanes, then drain, decision, winner read and update follow, and
// result_strobe pulses after the update. A start without ring_valid only counts the
// tick and gives no result. No new tick is taken while busy. No result stalls.
// Reset (rst, synchronous) restores registers, clears count, ticks, lesion.
module growing_vq_bearing_estimator #(
  parameter int RING_SIZE   = gvq_pkg::RING_SIZE_DEF,
  parameter int PROTO_MAX   = gvq_pkg::PROTO_MAX_DEF,
  parameter int SAMPLE_BITS = gvq_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] ring_sample_0,
  input  logic [15:0] ring_sample_1,
  input  logic [15:0] ring_sample_2,
  input  logic [15:0] ring_sample_3,
  input  logic [15:0] ring_sample_4,
  input  logic [15:0] ring_sample_5,
  input  logic [15:0] ring_sample_6,
  input  logic [15:0] ring_sample_7,
  input  logic        ring_valid,
  input  logic signed [15:0] teacher_x,
  input  logic signed [15:0] teacher_y,
  input  logic        teacher_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_strobe,
  output logic signed [15:0] inferred_x,
  output logic signed [15:0] inferred_y,
  output logic [15:0] proximity,
  output logic [4:0]  winner_index,
  output logic        grew_prototype,
  output logic        is_lesioned
);
  import gvq_pkg::*;

  localparam int PB  = (PROTO_MAX > 1) ? $clog2(PROTO_MAX) : 1;
  localparam int CB  = $clog2(PROTO_MAX + 1);
  localparam int SW  = SAMPLE_BITS * RING_SIZE;
  localparam int DW  = 2*SAMPLE_BITS + 3;
  localparam int SMB = SAMPLE_BITS + 4;

  // ceil(2^34/5): exact floor division by 5 for any operand below 2^32
  localparam logic [31:0] DIV5_MUL = 32'hCCCC_CCCD;

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DRAIN = 3'd2,
                         S_DEC = 3'd3, S_RD = 3'd4, S_UPD = 3'd5;

  // Configuration registers
  logic [15:0] novelty_threshold, prototype_rate, bearing_rate;
  logic [31:0] lesion_after;
  logic [5:0]  prototype_limit;

  logic [2:0]  state;
  logic [CB-1:0] count;
  logic [31:0] ticks;
  logic        lesioned;

  // Latched item
  logic [RING_SIZE-1:0][SAMPLE_BITS-1:0] ring;
  logic signed [15:0] tx, ty;
  logic        teach;
  logic [15:0] ring_in [8];

  // Scan
  logic [CB-1:0] scan_idx;
  logic          rd_valid, sq_valid;
  logic [PB-1:0] rd_idx, sq_idx;
  logic [PB-1:0] raddr;
  logic [SW-1:0] proto_rdata;
  logic [RING_SIZE-1:0][2*SAMPLE_BITS-1:0] sq;
  logic          have_best;
  logic [DW-1:0] best;
  logic [PB-1:0] best_idx;

  // Decision
  logic [PB-1:0] win;
  logic          grew;
  logic [SMB-1:0] sum, sum_in;
  logic signed [15:0] seed_x, seed_y;

  // Memory write ports
  logic          p_we, b_we;
  logic [PB-1:0] p_waddr;
  logic [SW-1:0] p_wdata;
  logic [31:0]   b_wdata, b_rdata;

  assign ring_in[0] = ring_sample_0;
  assign ring_in[1] = ring_sample_1;
  assign ring_in[2] = ring_sample_2;
  assign ring_in[3] = ring_sample_3;
  assign ring_in[4] = ring_sample_4;
  assign ring_in[5] = ring_sample_5;
  assign ring_in[6] = ring_sample_6;
  assign ring_in[7] = ring_sample_7;

  // Sum of the incoming ring, latched with the item
  always_comb begin
    sum_in = '0;
    for (int i = 0; i < RING_SIZE; i++) sum_in = sum_in + SMB'(SAMPLE_BITS'(ring_in[i]));
  end

  // A start transfer takes priority; config is taken only when idle and no start
  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  // Lesion checked at the start of each tick, sticky thereafter
  logic les_now;
  assign les_now = lesioned || (!lesion_after[31] && ticks >= lesion_after);

  gvq_ram #(.WIDTH(SW), .DEPTH(PROTO_MAX)) u_proto (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(raddr), .rdata(proto_rdata)
  );
  gvq_ram #(.WIDTH(32), .DEPTH(PROTO_MAX)) u_bear (
    .clk(clk), .we(b_we), .waddr(p_waddr), .wdata(b_wdata),
    .raddr(raddr), .rdata(b_rdata)
  );

  for (genvar g = 0; g < RING_SIZE; g++) begin : g_lane
    gvq_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk(clk), .ring(ring[g]),
      .proto(proto_rdata[g*SAMPLE_BITS +: SAMPLE_BITS]), .sq(sq[g])
    );
  end

  gvq_merge #(.RING_SIZE(RING_SIZE), .SAMPLE_BITS(SAMPLE_BITS), .IDX_BITS(PB)) u_merge (
    .clk(clk), .clear(state == S_IDLE), .sq_valid(sq_valid), .sq_idx(sq_idx),
    .sq(sq), .have_best(have_best), .best(best), .best_idx(best_idx)
  );

  // Address the RAMs: scan index while scanning, nearest prototype afterwards.
  // The nearest row is the winner unless a prototype grows, and then its
  // bearing seeds the new one if no teacher is latched.
  assign raddr = (state == S_SCAN) ? scan_idx[PB-1:0] : best_idx;

  // Effective limit: clamp to 1..PROTO_MAX
  logic [CB-1:0] eff_lim;
  always_comb begin
    if (prototype_limit == 6'd0) eff_lim = CB'(1);
    else if (32'(prototype_limit) > PROTO_MAX) eff_lim = CB'(PROTO_MAX);
    else eff_lim = CB'(prototype_limit);
  end

  // Proximity: floor(4*sum/5) by reciprocal multiplication
  logic [SMB+2:0] sum4;
  logic [SMB+2:0] prox_full;
  logic [SMB+34:0] prox_prod;
  always_comb begin
    sum4      = {sum, 2'b00};
    prox_prod = (SMB+35)'(sum4) * (SMB+35)'(DIV5_MUL);
    prox_full = (SMB+3)'(prox_prod >> 34);
  end

  // Update datapath (winner row, registered read)
  logic [SW-1:0] upd_row;
  logic signed [15:0] cur_x, cur_y, new_x, new_y;
  always_comb begin
    for (int i = 0; i < RING_SIZE; i++) begin
      upd_row[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(rate_step(
        26'($signed({1'b0, proto_rdata[i*SAMPLE_BITS +: SAMPLE_BITS]})),
        26'($signed({1'b0, ring[i]})), prototype_rate));
    end
    cur_x = (grew && (teach || !have_best)) ? seed_x : $signed(b_rdata[15:0]);
    cur_y = (grew && (teach || !have_best)) ? seed_y : $signed(b_rdata[31:16]);
    new_x = teach ? 16'(rate_step(26'(cur_x), 26'(tx), bearing_rate)) : cur_x;
    new_y = teach ? 16'(rate_step(26'(cur_y), 26'(ty), bearing_rate)) : cur_y;
  end

  // Row being updated: the ring itself when just grown
  logic [SW-1:0] grown_row;
  always_comb begin
    for (int i = 0; i < RING_SIZE; i++) begin
      grown_row[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(rate_step(
        26'($signed({1'b0, ring[i]})), 26'($signed({1'b0, ring[i]})), prototype_rate));
    end
  end

  always_comb begin
    p_we    = (state == S_UPD);
    b_we    = (state == S_UPD);
    p_waddr = win;
    p_wdata = grew ? grown_row : upd_row;
    b_wdata = {new_y, new_x};
  end

  logic [31:0] thr2;
  assign thr2 = novelty_threshold * novelty_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      novelty_threshold <= 16'd205;
      prototype_rate    <= 16'd3277;
      bearing_rate      <= 16'd3277;
      lesion_after      <= 32'hFFFF_FFFF;
      prototype_limit   <= 6'd24;
      count             <= '0;
      ticks             <= '0;
      lesioned          <= 1'b0;
      result_strobe     <= 1'b0;
      rd_valid          <= 1'b0;
      sq_valid          <= 1'b0;
    end else begin
      result_strobe <= (state == S_UPD);
      sq_valid      <= rd_valid;
      sq_idx        <= rd_idx;
      rd_valid      <= (state == S_SCAN) && (scan_idx < count);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lesioned <= les_now;
            if (ticks != 32'hFFFF_FFFF) ticks <= ticks + 32'd1;
            if (ring_valid) begin
              for (int i = 0; i < RING_SIZE; i++) begin
                ring[i] <= SAMPLE_BITS'(ring_in[i]);
              end
              sum      <= sum_in;
              tx       <= teacher_x;
              ty       <= teacher_y;
              teach    <= !les_now && teacher_valid;
              scan_idx <= '0;
              state    <= S_SCAN;
            end
          end else if (cfg_valid) begin
            unique case (cfg_index)
              REG_THRESHOLD:  novelty_threshold <= cfg_data[15:0];
              REG_PROTO_RATE: prototype_rate    <= cfg_data[15:0];
              REG_BEAR_RATE:  bearing_rate      <= cfg_data[15:0];
              REG_LESION_AFT: lesion_after      <= cfg_data;
              REG_FORCE_LES: begin
                // Set lesion at once; a written zero never clears it
                if (cfg_data[0]) lesioned <= 1'b1;
              end
              REG_PROTO_LIM:  prototype_limit   <= cfg_data[5:0];
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // Issue one prototype read per cycle
          if (scan_idx < count) begin
            rd_idx   <= scan_idx[PB-1:0];
            scan_idx <= scan_idx + CB'(1);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_valid && !sq_valid) state <= S_DEC;
        end
        S_DEC: begin
          if ((!have_best || best > DW'(thr2)) && count < eff_lim) begin
            grew   <= 1'b1;
            win    <= count[PB-1:0];
            count  <= count + CB'(1);
            // teacher seeds the new bearing; else the nearest one, read in S_RD, or zero with none
            seed_x <= teach ? tx : 16'sd0;
            seed_y <= teach ? ty : 16'sd0;
          end else begin
            grew <= 1'b0;
            win  <= best_idx;
          end
          state <= S_RD;
        end
        S_RD: begin
          // nearest row and bearing read issued via raddr
          state <= S_UPD;
        end
        S_UPD: begin
          inferred_x     <= new_x;
          inferred_y     <= new_y;
          proximity      <= (prox_full > (SMB+3)'(PROX_CAP)) ? PROX_CAP : prox_full[15:0];
          winner_index   <= 5'(win);
          grew_prototype <= grew;
          is_lesioned    <= lesioned;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/gvq_checker.sv
// Port-level checker for the growing VQ bearing estimator, bound to the top
`include "growing_vq_bearing_estimator_macros.svh"
module gvq_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic result_strobe,
  input logic [15:0] proximity,
  input logic is_lesioned
);
  `GVQ_ASSERT_NXT(a_strobe_single, result_strobe, !result_strobe, "strobe held two cycles")
  `GVQ_ASSERT_IMP(a_prox_cap, result_strobe, proximity <= 16'd32768, "proximity above cap")
  `GVQ_ASSERT_IMP(a_cfg_idle, cfg_ready, !busy, "config accepted while busy")
  `GVQ_ASSERT_IMP(a_cfg_excl, cfg_valid && cfg_ready, !start, "config beside a start")
  `GVQ_ASSERT_NXT(a_lesion_sticky, result_strobe && is_lesioned,
                  !result_strobe || is_lesioned, "lesion cleared")
endmodule

bind growing_vq_bearing_estimator gvq_checker u_gvq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready), .result_strobe(result_strobe), .proximity(proximity),
  .is_lesioned(is_lesioned)
);
